/* hw/rtl/mntv_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mntv_pkg: shared types and constants for the MIDI note to voice CV block
// Voice and priority list sizes, message codes, register indexes, pitch math.
// ----------------------------------------------------------------------------
package mntv_pkg;

   localparam int VOICE_COUNT    = 8;
   localparam int PRIORITY_DEPTH = 128;

   localparam int VIDX_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int PRIO_AW = (PRIORITY_DEPTH > 1) ? $clog2(PRIORITY_DEPTH) : 1;
   localparam int PRIO_CW = $clog2(PRIORITY_DEPTH + 1);

   typedef logic [6:0]         note_type;
   typedef logic [6:0]         vel_type;
   typedef logic signed [20:0] pitch_type;
   typedef logic signed [17:0] bend_type;

   typedef enum logic [1:0] {
      CSR_POLY_MODE  = 2'd0,
      CSR_RECV_CHAN  = 2'd1,
      CSR_BEND_RANGE = 2'd2
   } csr_index_type;

   localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
   localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
   localparam logic [3:0] MSG_CONTROL  = 4'hB;
   localparam logic [3:0] MSG_BEND     = 4'hE;
   localparam logic [3:0] MSG_SYSTEM   = 4'hF;
   localparam note_type   SUSTAIN_CC   = 7'd64;
   localparam logic [6:0] MIDDLE_C     = 7'd60;
   localparam logic [3:0] RANGE_MIN    = 4'd1;
   localparam logic [3:0] RANGE_MAX    = 4'd12;
   localparam logic [3:0] RANGE_RESET  = 4'd2;
   localparam logic [4:0] CHAN_NONE    = 5'h1F;

   typedef struct packed {
      logic                 en;
      logic [PRIO_AW-1:0]   addr;
      note_type             data;
   } prio_wr_type;

   typedef struct packed {
      logic                 en;
      logic [PRIO_AW-1:0]   addr;
   } prio_rd_type;

   // semitone offset from middle C in 1/8192 steps, plus the bend offset
   function automatic pitch_type pitch_of(input note_type n, input bend_type b);
      logic signed [7:0] d;
      d = $signed({1'b0, n}) - $signed({1'b0, MIDDLE_C});
      return $signed({d, 13'b0}) + pitch_type'(b);
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/mntv_prio_list.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mntv_prio_list: last-note priority list storage
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module mntv_prio_list (
   input  wire                    clock,
   input  mntv_pkg::prio_wr_type  wr,
   input  mntv_pkg::prio_rd_type  rd,
   output mntv_pkg::note_type     rd_data
);
   import mntv_pkg::*;

   note_type mem [PRIORITY_DEPTH];
   note_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/midi_note_to_voice_cv.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// midi_note_to_voice_cv: MIDI channel messages to per-voice gate/pitch/velocity
// Poly allocation or mono last-note priority, sustain pedal and pitch bend.
// ----------------------------------------------------------------------------
//  channel | ports                                   | dir | transaction
//  req     | req_valid/ready, status, data_one/two   | in  | one MIDI message
//  rsp     | rsp_valid/ready, voice, gate, pitch...  | out | one voice update
//  csr     | csr_write_en, csr_index, csr_wdata      | in  | register write
//
// An ignored message is taken without leaving idle. Otherwise the voices are
// scanned one at a time (up to VOICE_COUNT), and each result is held while
// rsp_ready is low. Mono note messages first walk the priority list, one entry
// per cycle, and make a second pass when a full list drops its oldest entry.
// req_ready is high only while idle. Reset is synchronous; the priority list
// needs no clearing, its fill count marks the valid entries.
// ----------------------------------------------------------------------------
module midi_note_to_voice_cv (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire  [7:0]            req_status_byte,
   input  wire  [6:0]            req_data_one,
   input  wire  [6:0]            req_data_two,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic [2:0]            rsp_voice_index,
   output logic                  rsp_gate_on,
   output logic signed [20:0]    rsp_pitch_value,
   output logic [6:0]            rsp_velocity_value,
   output logic                  rsp_last_of_run,
   input  wire                   csr_write_en,
   input  wire  [1:0]            csr_index,
   input  wire  [4:0]            csr_wdata
);
   import mntv_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SCAN   = 7'b0000010,
      ST_PUSH   = 7'b0000100,
      ST_TOP_RD = 7'b0001000,
      ST_TOP_WT = 7'b0010000,
      ST_VOICE  = 7'b0100000,
      ST_OUT    = 7'b1000000
   } state_type;

   typedef enum logic [2:0] {
      OP_POLY_ON, OP_POLY_OFF, OP_MONO_ON, OP_MONO_OFF, OP_PEDAL, OP_BEND
   } op_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic        poly_ff, poly_in;
   logic [4:0]  chan_ff, chan_in;
   logic [3:0]  range_ff, range_in;
   logic        sustain_ff, sustain_in;
   bend_type    bend_ff, bend_in;
   logic [PRIO_CW-1:0] count_ff, count_in;

   logic      held_valid_ff [VOICE_COUNT];
   logic      held_valid_in [VOICE_COUNT];
   note_type  held_note_ff  [VOICE_COUNT];
   note_type  held_note_in  [VOICE_COUNT];
   logic      snd_valid_ff  [VOICE_COUNT];
   logic      snd_valid_in  [VOICE_COUNT];
   note_type  snd_note_ff   [VOICE_COUNT];
   note_type  snd_note_in   [VOICE_COUNT];
   logic      gate_ff       [VOICE_COUNT];
   logic      gate_in       [VOICE_COUNT];
   vel_type   vel_store_ff  [VOICE_COUNT];
   vel_type   vel_store_in  [VOICE_COUNT];
   pitch_type pitch_ff      [VOICE_COUNT];
   pitch_type pitch_in      [VOICE_COUNT];

   note_type  note_ff, note_in;
   vel_type   vel_ff, vel_in;
   logic      fresh_ff, fresh_in;
   logic [VIDX_W-1:0]  vc_ff, vc_in;
   logic [PRIO_CW-1:0] ptr_ff, ptr_in;
   logic [PRIO_CW-1:0] k_ff, k_in;
   logic      pend_ff, pend_in;
   logic      shift_ff, shift_in;
   logic      last_ff, last_in;

   logic [2:0]  out_voice_ff, out_voice_in;
   logic        out_gate_ff, out_gate_in;
   pitch_type   out_pitch_ff, out_pitch_in;
   vel_type     out_vel_ff, out_vel_in;

   prio_wr_type prio_wr;
   prio_rd_type prio_rd;
   note_type    prio_data;

   logic [VOICE_COUNT-1:0] match_vec;
   logic                   more_after;
   logic signed [13:0]     bend_raw;
   bend_type               bend_prod;
   logic [PRIO_CW-1:0]     top_idx;
   logic [3:0]             msg_type;
   logic                   chan_hit;
   logic                   has_note, vel_ok, set_held;
   note_type               new_note;
   pitch_type              new_pitch;
   logic                   new_gate;
   vel_type                new_vel;
   logic [4:0]             csr_chan;
   logic [3:0]             csr_range;

   mntv_prio_list u_prio_list (
      .clock   (clock),
      .wr      (prio_wr),
      .rd      (prio_rd),
      .rd_data (prio_data)
   );

   assign msg_type  = req_status_byte[7:4];
   assign chan_hit  = req_status_byte[7] && (msg_type != MSG_SYSTEM) &&
                      !chan_ff[4] && (chan_ff[3:0] == req_status_byte[3:0]);
   assign bend_raw  = $signed({~req_data_two[6], req_data_two[5:0], req_data_one});
   assign bend_prod = bend_raw * $signed({1'b0, range_ff});
   assign top_idx   = count_ff - 1'b1;
   assign csr_chan  = csr_wdata;
   assign csr_range = csr_wdata[3:0];

   // voices this message touches, and whether any is left above the current one
   always_comb begin
      match_vec  = '0;
      more_after = 1'b0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
         case (op_ff)
            OP_POLY_ON:  match_vec[i] = !snd_valid_ff[i];
            OP_POLY_OFF: match_vec[i] = held_valid_ff[i] && (held_note_ff[i] == note_ff);
            OP_PEDAL:    match_vec[i] = !held_valid_ff[i] && (poly_ff || i == 0);
            OP_BEND:     match_vec[i] = poly_ff || i == 0;
            default:     match_vec[i] = (i == 0);
         endcase
         if (match_vec[i] && (VIDX_W'(i) > vc_ff)) begin
            more_after = 1'b1;
         end
      end
   end

   // new values for the voice under the scan pointer
   always_comb begin
      has_note = 1'b0;
      vel_ok   = 1'b0;
      set_held = 1'b0;
      new_note = note_ff;
      case (op_ff)
         OP_POLY_ON: begin
            has_note = 1'b1;
            vel_ok   = 1'b1;
            set_held = 1'b1;
         end
         OP_MONO_ON: begin
            has_note = 1'b1;
            vel_ok   = fresh_ff;
            set_held = 1'b1;
         end
         OP_MONO_OFF: begin
            has_note = (count_ff != '0);
            set_held = has_note;
         end
         OP_BEND: begin
            has_note = snd_valid_ff[vc_ff];
            new_note = snd_note_ff[vc_ff];
         end
         default: ;
      endcase
      new_pitch = has_note ? pitch_of(new_note, bend_ff) : pitch_ff[vc_ff];
      new_gate  = has_note || (sustain_ff && gate_ff[vc_ff]);
      new_vel   = (has_note && vel_ok) ? vel_ff : vel_store_ff[vc_ff];
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      poly_in      = poly_ff;
      chan_in      = chan_ff;
      range_in     = range_ff;
      sustain_in   = sustain_ff;
      bend_in      = bend_ff;
      count_in     = count_ff;
      held_valid_in = held_valid_ff;
      held_note_in  = held_note_ff;
      snd_valid_in  = snd_valid_ff;
      snd_note_in   = snd_note_ff;
      gate_in       = gate_ff;
      vel_store_in  = vel_store_ff;
      pitch_in      = pitch_ff;
      note_in      = note_ff;
      vel_in       = vel_ff;
      fresh_in     = fresh_ff;
      vc_in        = vc_ff;
      ptr_in       = ptr_ff;
      k_in         = k_ff;
      pend_in      = 1'b0;
      shift_in     = shift_ff;
      last_in      = last_ff;
      out_voice_in = out_voice_ff;
      out_gate_in  = out_gate_ff;
      out_pitch_in = out_pitch_ff;
      out_vel_in   = out_vel_ff;
      prio_wr      = '0;
      prio_rd      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               note_in  = req_data_one;
               vel_in   = req_data_two;
               vc_in    = '0;
               ptr_in   = '0;
               k_in     = '0;
               shift_in = 1'b0;
               fresh_in = (count_ff == '0);
               if (chan_hit) begin
                  case (msg_type)
                     MSG_NOTE_ON, MSG_NOTE_OFF: begin
                        if (msg_type == MSG_NOTE_ON && req_data_two != '0) begin
                           op_in = poly_ff ? OP_POLY_ON : OP_MONO_ON;
                        end else begin
                           op_in = poly_ff ? OP_POLY_OFF : OP_MONO_OFF;
                        end
                        state_in = poly_ff ? ST_VOICE : ST_SCAN;
                     end
                     MSG_CONTROL: begin
                        if (req_data_one == SUSTAIN_CC) begin
                           sustain_in = req_data_two[6];
                           if (!req_data_two[6]) begin
                              op_in    = OP_PEDAL;
                              state_in = ST_VOICE;
                           end
                        end
                     end
                     MSG_BEND: begin
                        bend_in  = bend_prod;
                        op_in    = OP_BEND;
                        state_in = ST_VOICE;
                     end
                     default: ;
                  endcase
               end
            end
         end

         // compact the list: drop the note (or the oldest entry when shifting)
         ST_SCAN: begin
            if (ptr_ff < count_ff) begin
               prio_rd.en   = 1'b1;
               prio_rd.addr = ptr_ff[PRIO_AW-1:0];
               ptr_in       = ptr_ff + 1'b1;
               pend_in      = 1'b1;
            end
            if (pend_ff && (shift_ff || prio_data != note_ff)) begin
               prio_wr.en   = 1'b1;
               prio_wr.addr = k_ff[PRIO_AW-1:0];
               prio_wr.data = prio_data;
               k_in         = k_ff + 1'b1;
            end
            if (ptr_ff == count_ff && !pend_ff) begin
               count_in = k_ff;
               if (op_ff == OP_MONO_ON) begin
                  if (!shift_ff && k_ff >= PRIO_CW'(PRIORITY_DEPTH)) begin
                     shift_in = 1'b1;
                     ptr_in   = PRIO_CW'(1);
                     k_in     = '0;
                  end else begin
                     state_in = ST_PUSH;
                  end
               end else begin
                  state_in = (k_ff == '0) ? ST_VOICE : ST_TOP_RD;
               end
            end
         end

         ST_PUSH: begin
            prio_wr.en   = 1'b1;
            prio_wr.addr = count_ff[PRIO_AW-1:0];
            prio_wr.data = note_ff;
            count_in     = count_ff + 1'b1;
            state_in     = ST_VOICE;
         end

         ST_TOP_RD: begin
            prio_rd.en   = 1'b1;
            prio_rd.addr = top_idx[PRIO_AW-1:0];
            state_in     = ST_TOP_WT;
         end

         ST_TOP_WT: begin
            note_in  = prio_data;
            state_in = ST_VOICE;
         end

         ST_VOICE: begin
            if (match_vec[vc_ff]) begin
               if (op_ff == OP_POLY_OFF) begin
                  held_valid_in[vc_ff] = 1'b0;
               end else if (op_ff == OP_MONO_OFF) begin
                  held_valid_in[vc_ff] = has_note;
               end
               if (set_held) begin
                  held_valid_in[vc_ff] = 1'b1;
                  held_note_in[vc_ff]  = new_note;
               end
               snd_valid_in[vc_ff] = has_note;
               snd_note_in[vc_ff]  = has_note ? new_note : '0;
               gate_in[vc_ff]      = new_gate;
               vel_store_in[vc_ff] = new_vel;
               pitch_in[vc_ff]     = new_pitch;
               out_voice_in = 3'(vc_ff);
               out_gate_in  = new_gate;
               out_pitch_in = new_pitch;
               out_vel_in   = new_vel;
               last_in      = (op_ff == OP_POLY_ON) || !more_after;
               state_in     = ST_OUT;
            end else if (vc_ff == VIDX_W'(VOICE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               vc_in = vc_ff + 1'b1;
            end
         end

         ST_OUT: begin
            if (rsp_ready) begin
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  vc_in    = vc_ff + 1'b1;
                  state_in = ST_VOICE;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase

      if (csr_write_en) begin
         case (csr_index)
            CSR_POLY_MODE: begin
               poly_in    = csr_wdata[0];
               chan_in    = CHAN_NONE;
               sustain_in = 1'b0;
               bend_in    = '0;
               count_in   = '0;
               for (int i = 0; i < VOICE_COUNT; i++) begin
                  held_valid_in[i] = 1'b0;
                  held_note_in[i]  = '0;
                  snd_valid_in[i]  = 1'b0;
                  snd_note_in[i]   = '0;
                  gate_in[i]       = 1'b0;
                  vel_store_in[i]  = '0;
                  pitch_in[i]      = '0;
               end
            end
            CSR_RECV_CHAN: begin
               if (!csr_chan[4] || csr_chan == CHAN_NONE) begin
                  chan_in = csr_chan;
               end
            end
            CSR_BEND_RANGE: begin
               if (csr_range >= RANGE_MIN && csr_range <= RANGE_MAX) begin
                  range_in = csr_range;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         op_ff      <= OP_BEND;
         poly_ff    <= 1'b0;
         chan_ff    <= CHAN_NONE;
         range_ff   <= RANGE_RESET;
         sustain_ff <= 1'b0;
         bend_ff    <= '0;
         count_ff   <= '0;
         pend_ff    <= 1'b0;
         shift_ff   <= 1'b0;
         last_ff    <= 1'b0;
         vc_ff      <= '0;
         ptr_ff     <= '0;
         k_ff       <= '0;
         for (int i = 0; i < VOICE_COUNT; i++) begin
            held_valid_ff[i] <= 1'b0;
            held_note_ff[i]  <= '0;
            snd_valid_ff[i]  <= 1'b0;
            snd_note_ff[i]   <= '0;
            gate_ff[i]       <= 1'b0;
            vel_store_ff[i]  <= '0;
            pitch_ff[i]      <= '0;
         end
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         poly_ff       <= poly_in;
         chan_ff       <= chan_in;
         range_ff      <= range_in;
         sustain_ff    <= sustain_in;
         bend_ff       <= bend_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         shift_ff      <= shift_in;
         last_ff       <= last_in;
         vc_ff         <= vc_in;
         ptr_ff        <= ptr_in;
         k_ff          <= k_in;
         held_valid_ff <= held_valid_in;
         held_note_ff  <= held_note_in;
         snd_valid_ff  <= snd_valid_in;
         snd_note_ff   <= snd_note_in;
         gate_ff       <= gate_in;
         vel_store_ff  <= vel_store_in;
         pitch_ff      <= pitch_in;
      end
   end

   always_ff @(posedge clock) begin
      note_ff      <= note_in;
      vel_ff       <= vel_in;
      fresh_ff     <= fresh_in;
      out_voice_ff <= out_voice_in;
      out_gate_ff  <= out_gate_in;
      out_pitch_ff <= out_pitch_in;
      out_vel_ff   <= out_vel_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = (state_ff == ST_OUT);
   assign rsp_voice_index    = out_voice_ff;
   assign rsp_gate_on        = out_gate_ff;
   assign rsp_pitch_value    = out_pitch_ff;
   assign rsp_velocity_value = out_vel_ff;
   assign rsp_last_of_run    = last_ff;

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= PRIO_CW'(PRIORITY_DEPTH))
      else $error("priority list count overflow");

   a_mono_voice0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !poly_ff |-> rsp_voice_index == '0)
      else $error("mono mode updated a voice other than 0");
`endif

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for midi_note_to_voice_cv
// Drives MIDI messages under random idling and stalls, predicts voice updates
// in poly and mono modes with sustain and bend, and compares every update.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mntv_pkg::*;

   typedef struct {
      logic [2:0]         voice;
      logic               gate;
      logic signed [20:0] pitch;
      logic [6:0]         vel;
      logic               last;
   } voice_update_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   wire  req_ready;
   logic [7:0] req_status_byte = '0;
   logic [6:0] req_data_one = '0;
   logic [6:0] req_data_two = '0;
   wire  rsp_valid;
   logic rsp_ready = 1'b0;
   wire  [2:0] rsp_voice_index;
   wire  rsp_gate_on;
   wire  signed [20:0] rsp_pitch_value;
   wire  [6:0] rsp_velocity_value;
   wire  rsp_last_of_run;
   logic csr_write_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [4:0] csr_wdata = '0;

   midi_note_to_voice_cv DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic                 poly;
   int                   chan;
   int                   range;
   logic [6:0]           key_note [8];
   logic                 key_held [8];
   logic [6:0]           snd_note [8];
   logic                 snd_on [8];
   logic                 gate [8];
   logic [6:0]           vel [8];
   logic signed [20:0]   pitch [8];
   logic                 sustain;
   int                   bend;
   logic [6:0]           note_stack [$];

   voice_update_type     expected_updates [$];
   int                   errors = 0;
   int                   cycles = 0;
   int                   send_idle_pct = 0;
   int                   stall_pct = 0;
   int                   hold_off = 0;
   bit                   offering = 1'b0;

   function automatic void clear_voices();
      for (int v = 0; v < 8; v++) begin
         key_note[v] = '0; key_held[v] = 0; snd_note[v] = '0; snd_on[v] = 0;
         gate[v] = 0; vel[v] = '0; pitch[v] = '0;
      end
      sustain = 0;
      bend = 0;
      note_stack.delete();
   endfunction

   function automatic void drive_voice(int v, logic has, logic [6:0] n, logic take,
                                       logic [6:0] vl);
      if (has) begin
         pitch[v] = 21'((int'(n) - 60) * 8192 + bend);
         gate[v] = 1;
         if (take) vel[v] = vl;
      end else if (!sustain) begin
         gate[v] = 0;
      end
      snd_on[v] = has;
      snd_note[v] = has ? n : '0;
   endfunction

   function automatic void push_update(int v);
      voice_update_type u;
      u.voice = 3'(v); u.gate = gate[v]; u.pitch = pitch[v]; u.vel = vel[v]; u.last = 0;
      expected_updates = {expected_updates, u};
   endfunction

   function automatic void drop_note(logic [6:0] n);
      for (int i = note_stack.size() - 1; i >= 0; i--)
         if (note_stack[i] == n) note_stack.delete(i);
   endfunction

   function automatic void release_key(logic [6:0] n);
      if (poly) begin
         for (int v = 0; v < 8; v++)
            if (key_held[v] && key_note[v] == n) begin
               key_held[v] = 0;
               drive_voice(v, 0, '0, 0, '0);
               push_update(v);
            end
      end else begin
         drop_note(n);
         if (note_stack.size() == 0) begin
            key_held[0] = 0;
            drive_voice(0, 0, '0, 0, '0);
         end else begin
            key_held[0] = 1;
            key_note[0] = note_stack[$];
            drive_voice(0, 1, key_note[0], 0, '0);
         end
         push_update(0);
      end
   endfunction

   function automatic void press_key(logic [6:0] n, logic [6:0] vl);
      logic fresh;
      if (poly) begin
         for (int v = 0; v < 8; v++)
            if (!snd_on[v]) begin
               key_held[v] = 1; key_note[v] = n;
               drive_voice(v, 1, n, 1, vl);
               push_update(v);
               return;
            end
         return;
      end
      fresh = (note_stack.size() == 0);
      drop_note(n);
      // full list: drop the oldest note
      if (note_stack.size() >= PRIORITY_DEPTH) void'(note_stack.pop_front());
      note_stack = {note_stack, n};
      key_held[0] = 1; key_note[0] = n;
      drive_voice(0, 1, n, fresh, vl);
      push_update(0);
   endfunction

   function automatic void predict_message(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
      int queued_at_start;
      queued_at_start = expected_updates.size();
      if (st < 8'h80 || st >= 8'hF0 || int'(st[3:0]) != chan) return;
      case (st[7:4])
         MSG_NOTE_ON: begin
            if (d2 == 0) release_key(d1); else press_key(d1, d2);
         end
         MSG_NOTE_OFF: release_key(d1);
         MSG_CONTROL: begin
            if (d1 == SUSTAIN_CC) begin
               if (d2[6]) sustain = 1;
               else begin
                  sustain = 0;
                  for (int v = 0; v < (poly ? 8 : 1); v++)
                     if (!key_held[v]) begin
                        drive_voice(v, 0, '0, 0, '0);
                        push_update(v);
                     end
               end
            end
         end
         MSG_BEND: begin
            bend = (int'({d2, d1}) - 8192) * range;
            for (int v = 0; v < (poly ? 8 : 1); v++) begin
               drive_voice(v, snd_on[v], snd_note[v], 0, '0);
               push_update(v);
            end
         end
         default: ;
      endcase
      if (expected_updates.size() > queued_at_start)
         expected_updates[$].last = 1;
   endfunction

   // drop valid once the sender has nothing more to offer
   task automatic stop_offer();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   task automatic wait_drained();
      stop_offer();
      while (expected_updates.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [4:0] val);
      int c;
      wait_drained();
      // let any silent message finish before touching registers
      repeat (300) @(posedge clock);
      csr_write_en <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_POLY_MODE: begin poly = val[0]; clear_voices(); chan = -1; end
         CSR_RECV_CHAN: begin
            c = val[4] ? int'(val) - 32 : int'(val);
            if (c >= -1) chan = c;
         end
         CSR_BEND_RANGE: if (val[3:0] >= RANGE_MIN && val[3:0] <= RANGE_MAX)
            range = val[3:0];
         default: ;
      endcase
   endtask

   task automatic send_message(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
      while ($urandom_range(99) < send_idle_pct) begin
         stop_offer();
         @(posedge clock);
      end
      req_valid <= 1'b1; req_status_byte <= st; req_data_one <= d1; req_data_two <= d2;
      offering = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_message(st, d1, d2);
   endtask

   // response side: sample at the edge, decide readiness for the next one
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_updates.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected update voice %0d", rsp_voice_index);
         end else begin
            voice_update_type e;
            e = expected_updates.pop_front();
            if (e.voice !== rsp_voice_index || e.gate !== rsp_gate_on ||
                e.pitch !== rsp_pitch_value || e.vel !== rsp_velocity_value ||
                e.last !== rsp_last_of_run) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch exp v%0d g%0d p%0d vel%0d l%0d got v%0d g%0d p%0d vel%0d l%0d",
                     e.voice, e.gate, e.pitch, e.vel, e.last, rsp_voice_index, rsp_gate_on,
                     rsp_pitch_value, rsp_velocity_value, rsp_last_of_run);
            end
         end
      end
      if (hold_off > 0) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // long receiver stall: count it down
   always @(posedge clock) begin
      if (hold_off > 0) hold_off <= hold_off - 1;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 2000000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [7:0] on_chan(logic [3:0] kind);
      return {kind, 4'(chan)};
   endfunction

   task automatic test_poly_directed();
      write_reg(CSR_POLY_MODE, 5'd1);
      write_reg(CSR_RECV_CHAN, 5'd3);
      write_reg(CSR_BEND_RANGE, 5'd12);
      for (int i = 0; i < 9; i++) send_message(on_chan(MSG_NOTE_ON), 7'(i * 15 + 7), 7'(i + 1));
      send_message(on_chan(MSG_NOTE_ON), 7'd127, 7'd127);
      send_message(on_chan(MSG_BEND), 7'd0, 7'd0);
      send_message(on_chan(MSG_BEND), 7'd127, 7'd127);
      send_message(on_chan(MSG_CONTROL), SUSTAIN_CC, 7'd127);
      send_message(on_chan(MSG_NOTE_OFF), 7'd7, 7'd0);
      send_message(on_chan(MSG_NOTE_ON), 7'd22, 7'd0);
      send_message(on_chan(MSG_CONTROL), SUSTAIN_CC, 7'd63);
      send_message(on_chan(MSG_CONTROL), 7'd1, 7'd0);
      send_message(8'hA3, 7'd5, 7'd5);
      send_message(8'h94, 7'd5, 7'd5);
      send_message(8'hF3, 7'd5, 7'd5);
      send_message(8'h13, 7'd5, 7'd5);
      send_message(on_chan(MSG_NOTE_OFF), 7'd99, 7'd0);
      write_reg(CSR_BEND_RANGE, 5'd0);
      write_reg(CSR_BEND_RANGE, 5'd13);
      write_reg(CSR_RECV_CHAN, 5'h10);
      wait_drained();
   endtask

   task automatic test_mono_directed();
      write_reg(CSR_POLY_MODE, 5'd0);
      send_message(8'h90, 7'd60, 7'd100);
      write_reg(CSR_RECV_CHAN, 5'd0);
      write_reg(CSR_BEND_RANGE, 5'd1);
      send_message(8'h90, 7'd60, 7'd100);
      send_message(8'h90, 7'd64, 7'd10);
      send_message(8'h90, 7'd60, 7'd20);
      send_message(8'h80, 7'd60, 7'd0);
      send_message(8'h80, 7'd5, 7'd0);
      send_message(8'hE0, 7'd0, 7'd64);
      send_message(8'h80, 7'd64, 7'd0);
      send_message(8'hB0, SUSTAIN_CC, 7'd0);
      wait_drained();
   endtask

   task automatic random_phase(bit use_poly, int n, int idle, int stall, bit pressure);
      logic [7:0] st;
      logic [6:0] d1, d2;
      logic [3:0] kinds [5] = '{MSG_NOTE_ON, MSG_NOTE_OFF, MSG_CONTROL, MSG_BEND, MSG_NOTE_ON};
      wait_drained();
      write_reg(CSR_POLY_MODE, 5'(use_poly));
      write_reg(CSR_RECV_CHAN, 5'($urandom_range(15)));
      write_reg(CSR_BEND_RANGE, 5'($urandom_range(12, 1)));
      send_idle_pct = idle; stall_pct = stall;
      if (pressure) hold_off = 400;
      for (int i = 0; i < n; i++) begin
         d1 = 7'($urandom_range(127));
         d2 = 7'($urandom_range(127));
         if ($urandom_range(9) == 0) begin
            st = 8'($urandom_range(255));
         end else begin
            st = on_chan(kinds[$urandom_range(4)]);
            if (st[7:4] != MSG_BEND) d1 = 7'($urandom_range(72, 48));
            if (st[7:4] == MSG_CONTROL && $urandom_range(1)) d1 = SUSTAIN_CC;
         end
         send_message(st, d1, d2);
      end
      wait_drained();
      send_idle_pct = 0; stall_pct = 0;
   endtask

   initial begin
      clear_voices();
      poly = 0; chan = -1; range = 2;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_poly_directed();
      test_mono_directed();
      random_phase(1, 40, 0, 0, 1);
      random_phase(0, 40, 49, 0, 0);
      random_phase(1, 40, 0, 49, 0);
      random_phase(0, 40, 22, 22, 1);
      random_phase(1, 40, 22, 22, 0);
      repeat (300) @(posedge clock);
      if (errors == 0 && expected_updates.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
